/* hw/rtl/vlss_pkg.sv */
// ----------------------------------------------------------------------------
// vlss_pkg
// Shared types and codes for the vehicle light and switch state block:
// device codes, flag positions, broadcast group bits and the channel words.
// ----------------------------------------------------------------------------
package vlss_pkg;

    // device codes carried in cmd
    typedef enum logic [3:0] {
        DEV_IGNITION    = 4'd0,
        DEV_STARTER     = 4'd1,
        DEV_HORN        = 4'd2,
        DEV_LEFT        = 4'd3,
        DEV_RIGHT       = 4'd4,
        DEV_BRAKE_LEVER = 4'd5,
        DEV_BRAKE_PEDAL = 4'd6,
        DEV_PARK        = 4'd7,
        DEV_MAIN        = 4'd8,
        DEV_MULTI       = 4'd9,
        DEV_LOW         = 4'd10,
        DEV_HIGH        = 4'd11,
        DEV_TOGGLE      = 4'd12
    } dev_t;

    // feature flag positions
    localparam int unsigned NUM_FLAGS  = 9;
    localparam int unsigned FLAG_IGN   = 0;
    localparam int unsigned FLAG_START = 1;
    localparam int unsigned FLAG_HORN  = 2;
    localparam int unsigned FLAG_LEFT  = 3;
    localparam int unsigned FLAG_RIGHT = 4;
    localparam int unsigned FLAG_BRAKE = 5;
    localparam int unsigned FLAG_PARK  = 6;
    localparam int unsigned FLAG_LOW   = 7;
    localparam int unsigned FLAG_HIGH  = 8;

    // broadcast group bits
    localparam int unsigned NUM_GROUPS = 6;
    localparam logic [5:0] GRP_NONE  = 6'h00;
    localparam logic [5:0] GRP_IGN   = 6'h01;
    localparam logic [5:0] GRP_START = 6'h02;
    localparam logic [5:0] GRP_HORN  = 6'h04;
    localparam logic [5:0] GRP_IND   = 6'h08;
    localparam logic [5:0] GRP_BRAKE = 6'h10;
    localparam logic [5:0] GRP_LIGHT = 6'h20;

    // multifunction button steps
    typedef enum logic [1:0] {
        STEP_OFF      = 2'd0,
        STEP_PARK     = 2'd1,
        STEP_PARK_LOW = 2'd2,
        STEP_WRAP     = 2'd3
    } step_t;

    // switch event word
    typedef struct packed {
        logic [3:0] cmd;
        logic       pressed;
        logic       physical_level;
    } sw_word_t;

    // state report word
    typedef struct packed {
        logic       ign_on;
        logic       crank_on;
        logic       horn_on;
        logic       left_on;
        logic       right_ind_on;
        logic       brake_on;
        logic       park_on;
        logic       dip_beam_on;
        logic       full_beam_on;
        logic [5:0] raised_mask;
    } st_word_t;

endpackage

/* hw/rtl/vehicle_light_switch_state.sv */
// ----------------------------------------------------------------------------
// vehicle_light_switch_state
// Keeps the vehicle feature flags from a stream of switch events and reports
// all flags plus the broadcast groups raised by each event.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | word
//  --------+-----+---------------------+-------------------------------------
//  sw      | in  | sw_valid / sw_ready | cmd, pressed, physical_level
//  st      | out | st_valid / st_ready | nine flags, raised_mask
//
//  one event accepted per cycle while sw_ready is high; an event is taken into
//  the event register, then the report register loads with the flag update
//  between them
//  the flags and edge detectors update in the cycle the report register loads
//  reset clears flags, step counter, edge detectors and both valid bits
//  a stalled st_ready holds the report; the event register keeps taking a
//  word until it is full, then sw_ready drops
// ----------------------------------------------------------------------------
module vehicle_light_switch_state
    import vlss_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     sw_valid,
    output logic     sw_ready,
    input  sw_word_t sw_data,
    output logic     st_valid,
    input  logic     st_ready,
    output st_word_t st_data
);

    // pipeline registers
    logic     ev_valid_reg;
    sw_word_t ev_reg;
    logic     st_valid_reg;
    st_word_t st_reg;
    st_word_t st_next;

    // block state
    logic [NUM_FLAGS-1:0] flags_reg, flags_next;
    logic                 multi_prev_reg, multi_prev_next;
    step_t                step_reg, step_next;
    logic                 tog_prev_reg, tog_prev_next;
    logic                 tog_ff_reg, tog_ff_next;
    logic [NUM_GROUPS-1:0] mask_next;

    logic ev_take;
    logic st_load;

    // handshake
    assign st_load  = ev_valid_reg && (!st_valid_reg || st_ready);
    assign sw_ready = !ev_valid_reg || st_load;
    assign ev_take  = sw_valid && sw_ready;
    assign st_valid = st_valid_reg;
    assign st_data  = st_reg;

    // flag update for the registered event
    always_comb
    begin
        logic pr;
        logic ph;
        logic hb;
        pr              = ev_reg.pressed;
        ph              = ev_reg.physical_level;
        hb              = 1'b0;
        flags_next      = flags_reg;
        multi_prev_next = multi_prev_reg;
        step_next       = step_reg;
        tog_prev_next   = tog_prev_reg;
        tog_ff_next     = tog_ff_reg;
        mask_next       = GRP_NONE;
        case (ev_reg.cmd)
            DEV_IGNITION:
            begin
                flags_next[FLAG_IGN] = pr;
                if (flags_reg[FLAG_IGN] != pr) mask_next = GRP_IGN;
            end
            DEV_STARTER:
            begin
                flags_next[FLAG_START] = pr;
                if (flags_reg[FLAG_START] != pr) mask_next = GRP_START;
            end
            DEV_HORN:
            begin
                flags_next[FLAG_HORN] = pr;
                if (flags_reg[FLAG_HORN] != pr) mask_next = GRP_HORN;
            end
            DEV_LEFT:
            begin
                flags_next[FLAG_LEFT] = pr;
                if (flags_reg[FLAG_LEFT] != pr) mask_next = GRP_IND;
            end
            DEV_RIGHT:
            begin
                flags_next[FLAG_RIGHT] = pr;
                if (flags_reg[FLAG_RIGHT] != pr) mask_next = GRP_IND;
            end
            DEV_BRAKE_LEVER, DEV_BRAKE_PEDAL:
            begin
                flags_next[FLAG_BRAKE] = ph;
                if (flags_reg[FLAG_BRAKE] != ph) mask_next = GRP_BRAKE;
            end
            DEV_PARK:
            begin
                flags_next[FLAG_PARK] = pr;
                if (flags_reg[FLAG_PARK] != pr) mask_next = GRP_LIGHT;
            end
            DEV_MAIN, DEV_LOW:
            begin
                if (flags_reg[FLAG_LOW] != pr)
                begin
                    flags_next[FLAG_LOW] = pr;
                    if (!pr) flags_next[FLAG_HIGH] = 1'b0;
                    mask_next = GRP_LIGHT;
                end
            end
            DEV_MULTI:
            begin
                // rising edge steps off, park, park plus low beam
                if (ph && !multi_prev_reg)
                begin
                    case (step_reg)
                        STEP_OFF:  step_next = STEP_PARK;
                        STEP_PARK: step_next = STEP_PARK_LOW;
                        default:   step_next = STEP_OFF;
                    endcase
                    flags_next[FLAG_PARK] = (step_next != STEP_OFF);
                    flags_next[FLAG_LOW]  = (step_next == STEP_PARK_LOW);
                    if (step_next != STEP_PARK_LOW) flags_next[FLAG_HIGH] = 1'b0;
                    mask_next = GRP_LIGHT;
                end
                multi_prev_next = ph;
            end
            DEV_HIGH:
            begin
                flags_next[FLAG_HIGH] = pr;
                if (flags_reg[FLAG_HIGH] != pr) mask_next = GRP_LIGHT;
            end
            DEV_TOGGLE:
            begin
                // flip on rising edge while low beam is on, else follow level
                if (flags_reg[FLAG_LOW])
                begin
                    if (ph && !tog_prev_reg) tog_ff_next = !tog_ff_reg;
                    hb = tog_ff_next;
                end
                else
                begin
                    tog_ff_next = 1'b0;
                    hb          = ph;
                end
                tog_prev_next          = ph;
                flags_next[FLAG_HIGH]  = hb;
                if (flags_reg[FLAG_HIGH] != hb) mask_next = GRP_LIGHT;
            end
            default:
            begin
                flags_next = flags_reg;
            end
        endcase
    end

    // report word
    always_comb
    begin
        st_next.ign_on       = flags_next[FLAG_IGN];
        st_next.crank_on     = flags_next[FLAG_START];
        st_next.horn_on      = flags_next[FLAG_HORN];
        st_next.left_on      = flags_next[FLAG_LEFT];
        st_next.right_ind_on = flags_next[FLAG_RIGHT];
        st_next.brake_on     = flags_next[FLAG_BRAKE];
        st_next.park_on      = flags_next[FLAG_PARK];
        st_next.dip_beam_on  = flags_next[FLAG_LOW];
        st_next.full_beam_on = flags_next[FLAG_HIGH];
        st_next.raised_mask  = mask_next;
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_valid_reg   <= 1'b0;
            st_valid_reg   <= 1'b0;
            flags_reg      <= '0;
            multi_prev_reg <= 1'b0;
            step_reg       <= STEP_OFF;
            tog_prev_reg   <= 1'b0;
            tog_ff_reg     <= 1'b0;
        end
        else
        begin
            if (sw_ready) ev_valid_reg <= sw_valid;
            if (st_load)
            begin
                st_valid_reg   <= 1'b1;
                flags_reg      <= flags_next;
                multi_prev_reg <= multi_prev_next;
                step_reg       <= step_next;
                tog_prev_reg   <= tog_prev_next;
                tog_ff_reg     <= tog_ff_next;
            end
            else if (st_ready)
            begin
                st_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ev_take) ev_reg <= sw_data;
        if (st_load) st_reg <= st_next;
    end

    // at most one group is raised by any event
    assert property (@(posedge clk) disable iff (!rst_n)
        st_valid_reg |-> $onehot0(st_reg.raised_mask))
        else $error("more than one broadcast group raised");

    // the multifunction step never reaches the wrap code
    assert property (@(posedge clk) disable iff (!rst_n)
        step_reg != STEP_WRAP)
        else $error("multifunction step out of range");

    // the pending report always mirrors the stored flags
    assert property (@(posedge clk) disable iff (!rst_n)
        st_valid_reg |-> (st_reg.full_beam_on == flags_reg[FLAG_HIGH]
                       && st_reg.dip_beam_on == flags_reg[FLAG_LOW]
                       && st_reg.park_on == flags_reg[FLAG_PARK]))
        else $error("report flags differ from stored flags");

    // input back-pressure only with a full event register
    assert property (@(posedge clk) disable iff (!rst_n)
        !sw_ready |-> (ev_valid_reg && st_valid_reg))
        else $error("event channel stalled without a full pipeline");

endmodule
